/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/sgi_pkg.sv */
// ----------------------------------------------------------------------------
// sgi_pkg
// Status codes shared by the segment intersection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgi_pkg;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_HIT      = 2'd0;
   localparam status_type STATUS_PARALLEL = 2'd1;
   localparam status_type STATUS_OUTSIDE  = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/sgi_div_cell.sv */
// ----------------------------------------------------------------------------
// sgi_div_cell
// One restoring-division step for two lanes sharing a divisor; passes the
// partial remainder/quotient, the divisor and a tag on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgi_div_cell #(
   parameter int R  = 34,
   parameter int Q  = 32,
   parameter int TW = 36
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            valid_in,
   input  wire logic [R+Q-1:0]  zx_in,
   input  wire logic [R+Q-1:0]  zy_in,
   input  wire logic [R-1:0]    d_in,
   input  wire logic [TW-1:0]   tag_in,
   output logic                 valid_out,
   output logic [R+Q-1:0]       zx_out,
   output logic [R+Q-1:0]       zy_out,
   output logic [R-1:0]         d_out,
   output logic [TW-1:0]        tag_out
);

   localparam int ZW = R + Q;

   logic            valid_ff;
   logic [ZW-1:0]   zx_ff, zy_ff, zx_in_w, zy_in_w;
   logic [R-1:0]    d_ff;
   logic [TW-1:0]   tag_ff;
   logic [R:0]      tx, ty, rx, ry;
   logic            gex, gey;

   always_comb begin
      tx  = zx_in[ZW-1:Q-1];
      ty  = zy_in[ZW-1:Q-1];
      gex = tx >= {1'b0, d_in};
      gey = ty >= {1'b0, d_in};
      rx  = gex ? tx - {1'b0, d_in} : tx;
      ry  = gey ? ty - {1'b0, d_in} : ty;
      zx_in_w = {rx[R-1:0], zx_in[Q-2:0], gex};
      zy_in_w = {ry[R-1:0], zy_in[Q-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      zx_ff  <= zx_in_w;
      zy_ff  <= zy_in_w;
      d_ff   <= d_in;
      tag_ff <= tag_in;
   end

   assign valid_out = valid_ff;
   assign zx_out    = zx_ff;
   assign zy_out    = zy_ff;
   assign d_out     = d_ff;
   assign tag_out   = tag_ff;

endmodule

`default_nettype wire

/* rtl/core/segment_intersection_core.sv */
// ----------------------------------------------------------------------------
// segment_intersection_core
// 2D segment intersection: cross-product determinant, exact range tests and
// a fixed-point intersection point from a chain of division cells.
// ----------------------------------------------------------------------------
// Path: an accepted word passes stages 1 to 7, one division cell per quotient
// bit and final 1 to 3 before rsp_valid.
// Throughput: one word per cycle; busy stays low, results are never stalled.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module segment_intersection_core #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_a_start_x,
   input  wire logic signed [15:0] req_a_start_y,
   input  wire logic signed [15:0] req_a_end_x,
   input  wire logic signed [15:0] req_a_end_y,
   input  wire logic signed [15:0] req_b_start_x,
   input  wire logic signed [15:0] req_b_start_y,
   input  wire logic signed [15:0] req_b_end_x,
   input  wire logic signed [15:0] req_b_end_y,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_cross_x,
   output logic signed [31:0]      rsp_cross_y
);

   localparam int C  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int EW = (C > 16) ? C : 16;
   localparam int H  = C + 1;
   localparam int R  = 2 * H;
   localparam int DW = 2 * H + 1;
   localparam int MW = 3 * H + 1;
   localparam int Q  = C + F;
   localparam int NW = 3 * H + F;
   localparam int ZW = R + Q;
   localparam int TW = 4 + 2 * C;
   localparam int SW = C + F + 2;

   function automatic logic signed [C-1:0] coord(input logic [15:0] v);
      logic [EW-1:0] e;
      e = EW'(v);
      return e[C-1:0];
   endfunction

   // stage 1: differences
   logic                  v1_ff;
   logic signed [H-1:0]   dax_ff, day_ff, dbx_ff, dby_ff, ox_ff, oy_ff;
   logic signed [C-1:0]   ax1_ff, ay1_ff;
   logic signed [C-1:0]   ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

   always_comb begin
      ax1 = coord(req_a_start_x);
      ay1 = coord(req_a_start_y);
      ax2 = coord(req_a_end_x);
      ay2 = coord(req_a_end_y);
      bx1 = coord(req_b_start_x);
      by1 = coord(req_b_start_y);
      bx2 = coord(req_b_end_x);
      by2 = coord(req_b_end_y);
   end

   always_ff @(posedge clock) begin
      dax_ff <= H'(ax2) - H'(ax1);
      day_ff <= H'(ay2) - H'(ay1);
      dbx_ff <= H'(bx2) - H'(bx1);
      dby_ff <= H'(by2) - H'(by1);
      ox_ff  <= H'(bx1) - H'(ax1);
      oy_ff  <= H'(by1) - H'(ay1);
      ax1_ff <= ax1;
      ay1_ff <= ay1;
   end

   // stage 2: cross products
   logic                  v2_ff;
   logic signed [2*H-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [H-1:0]   dax2_ff, day2_ff;
   logic signed [C-1:0]   ax2_ff, ay2_ff;

   always_ff @(posedge clock) begin
      p1_ff   <= dbx_ff * day_ff;
      p2_ff   <= dby_ff * dax_ff;
      p3_ff   <= dbx_ff * oy_ff;
      p4_ff   <= dby_ff * ox_ff;
      p5_ff   <= dax_ff * oy_ff;
      p6_ff   <= day_ff * ox_ff;
      dax2_ff <= dax_ff;
      day2_ff <= day_ff;
      ax2_ff  <= ax1_ff;
      ay2_ff  <= ay1_ff;
   end

   // stage 3: determinant and numerators
   logic                  v3_ff;
   logic signed [DW-1:0]  det_ff, snum_ff, tnum_ff;
   logic signed [H-1:0]   dax3_ff, day3_ff;
   logic signed [C-1:0]   ax3_ff, ay3_ff;

   always_ff @(posedge clock) begin
      det_ff  <= DW'(p1_ff) - DW'(p2_ff);
      snum_ff <= DW'(p3_ff) - DW'(p4_ff);
      tnum_ff <= DW'(p5_ff) - DW'(p6_ff);
      dax3_ff <= dax2_ff;
      day3_ff <= day2_ff;
      ax3_ff  <= ax2_ff;
      ay3_ff  <= ay2_ff;
   end

   // stage 4: sign normalize and range tests
   logic                  v4_ff;
   logic [R-1:0]          detm_ff, snm_ff;
   sgi_pkg::status_type   st4_ff, st4;
   logic signed [H-1:0]   dax4_ff, day4_ff;
   logic signed [C-1:0]   ax4_ff, ay4_ff;
   logic signed [DW-1:0]  dn, sn, tn;

   always_comb begin
      dn = det_ff[DW-1] ? -det_ff : det_ff;
      sn = det_ff[DW-1] ? -snum_ff : snum_ff;
      tn = det_ff[DW-1] ? -tnum_ff : tnum_ff;
      if (det_ff == '0) begin
         st4 = sgi_pkg::STATUS_PARALLEL;
      end else if (sn[DW-1] || sn > dn || tn[DW-1] || tn > dn) begin
         st4 = sgi_pkg::STATUS_OUTSIDE;
      end else begin
         st4 = sgi_pkg::STATUS_HIT;
      end
   end

   always_ff @(posedge clock) begin
      detm_ff <= dn[R-1:0];
      snm_ff  <= sn[R-1:0];
      st4_ff  <= st4;
      dax4_ff <= dax3_ff;
      day4_ff <= day3_ff;
      ax4_ff  <= ax3_ff;
      ay4_ff  <= ay3_ff;
   end

   // stage 5: direction times s numerator, split in halves
   logic                  v5_ff;
   logic signed [2*H:0]   plx_ff, phx_ff, ply_ff, phy_ff;
   logic [R-1:0]          detm5_ff;
   sgi_pkg::status_type   st5_ff;
   logic signed [C-1:0]   ax5_ff, ay5_ff;

   always_ff @(posedge clock) begin
      plx_ff   <= dax4_ff * $signed({1'b0, snm_ff[H-1:0]});
      phx_ff   <= dax4_ff * $signed({1'b0, snm_ff[R-1:H]});
      ply_ff   <= day4_ff * $signed({1'b0, snm_ff[H-1:0]});
      phy_ff   <= day4_ff * $signed({1'b0, snm_ff[R-1:H]});
      detm5_ff <= detm_ff;
      st5_ff   <= st4_ff;
      ax5_ff   <= ax4_ff;
      ay5_ff   <= ay4_ff;
   end

   // stage 6: combine partial products
   logic                  v6_ff;
   logic signed [MW-1:0]  mx_ff, my_ff;
   logic [R-1:0]          detm6_ff;
   sgi_pkg::status_type   st6_ff;
   logic signed [C-1:0]   ax6_ff, ay6_ff;

   always_ff @(posedge clock) begin
      mx_ff    <= MW'(plx_ff) + (MW'(phx_ff) <<< H);
      my_ff    <= MW'(ply_ff) + (MW'(phy_ff) <<< H);
      detm6_ff <= detm5_ff;
      st6_ff   <= st5_ff;
      ax6_ff   <= ax5_ff;
      ay6_ff   <= ay5_ff;
   end

   // stage 7: magnitude, scale, load division chain
   logic                  v7_ff;
   logic [ZW-1:0]         z7x_ff, z7y_ff;
   logic [R-1:0]          detm7_ff;
   logic [TW-1:0]         tag7_ff;
   logic signed [MW-1:0]  magx, magy;
   logic [NW-1:0]         dvx, dvy;

   always_comb begin
      magx = mx_ff[MW-1] ? -mx_ff : mx_ff;
      magy = my_ff[MW-1] ? -my_ff : my_ff;
      dvx  = NW'(magx[3*H-1:0]) << F;
      dvy  = NW'(magy[3*H-1:0]) << F;
   end

   always_ff @(posedge clock) begin
      z7x_ff   <= dvx[ZW-1:0];
      z7y_ff   <= dvy[ZW-1:0];
      detm7_ff <= detm6_ff;
      tag7_ff  <= {st6_ff, mx_ff[MW-1], my_ff[MW-1], ax6_ff, ay6_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // division chain
   logic            cv   [0:Q];
   logic [ZW-1:0]   czx  [0:Q];
   logic [ZW-1:0]   czy  [0:Q];
   logic [R-1:0]    cd   [0:Q];
   logic [TW-1:0]   ctag [0:Q];

   assign cv[0]   = v7_ff;
   assign czx[0]  = z7x_ff;
   assign czy[0]  = z7y_ff;
   assign cd[0]   = detm7_ff;
   assign ctag[0] = tag7_ff;

   for (genvar i = 0; i < Q; i++) begin : g_cell
      sgi_div_cell #(
         .R  (R),
         .Q  (Q),
         .TW (TW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (cv[i]),
         .zx_in     (czx[i]),
         .zy_in     (czy[i]),
         .d_in      (cd[i]),
         .tag_in    (ctag[i]),
         .valid_out (cv[i+1]),
         .zx_out    (czx[i+1]),
         .zy_out    (czy[i+1]),
         .d_out     (cd[i+1]),
         .tag_out   (ctag[i+1])
      );
   end

   // final 1: add start point
   logic                  f1v_ff;
   logic signed [SW-1:0]  s1x_ff, s1y_ff;
   logic                  n1x_ff, n1y_ff, r1x_ff, r1y_ff;
   sgi_pkg::status_type   st_f1_ff;
   logic [TW-1:0]         tq;
   logic signed [C-1:0]   axq, ayq;
   logic signed [SW-1:0]  bx, by;

   always_comb begin
      tq  = ctag[Q];
      axq = tq[2*C-1:C];
      ayq = tq[C-1:0];
      bx  = SW'(axq) <<< F;
      by  = SW'(ayq) <<< F;
   end

   always_ff @(posedge clock) begin
      s1x_ff   <= tq[2*C+1] ? bx - $signed(SW'(czx[Q][Q-1:0]))
                            : bx + $signed(SW'(czx[Q][Q-1:0]));
      s1y_ff   <= tq[2*C] ? by - $signed(SW'(czy[Q][Q-1:0]))
                          : by + $signed(SW'(czy[Q][Q-1:0]));
      n1x_ff   <= tq[2*C+1];
      n1y_ff   <= tq[2*C];
      r1x_ff   <= |czx[Q][ZW-1:Q];
      r1y_ff   <= |czy[Q][ZW-1:Q];
      st_f1_ff <= tq[TW-1:TW-2];
   end

   // final 2: truncate toward zero
   logic                  f2v_ff;
   logic signed [SW-1:0]  s2x_ff, s2y_ff;
   sgi_pkg::status_type   st_f2_ff;
   logic                  adjx, adjy;

   always_comb begin
      adjx = r1x_ff && (n1x_ff ? (!s1x_ff[SW-1] && s1x_ff != '0) : s1x_ff[SW-1]);
      adjy = r1y_ff && (n1y_ff ? (!s1y_ff[SW-1] && s1y_ff != '0) : s1y_ff[SW-1]);
   end

   always_ff @(posedge clock) begin
      s2x_ff   <= adjx ? (n1x_ff ? s1x_ff - SW'(1) : s1x_ff + SW'(1)) : s1x_ff;
      s2y_ff   <= adjy ? (n1y_ff ? s1y_ff - SW'(1) : s1y_ff + SW'(1)) : s1y_ff;
      st_f2_ff <= st_f1_ff;
   end

   // final 3: saturate, output register
   logic                  f3v_ff;
   sgi_pkg::status_type   st_f3_ff;
   logic signed [31:0]    ox3_ff, oy3_ff, satx, saty;

   if (SW > 32) begin : g_sat
      always_comb begin
         if (s2x_ff[SW-1:31] == {(SW-31){s2x_ff[SW-1]}}) begin
            satx = s2x_ff[31:0];
         end else begin
            satx = s2x_ff[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end
         if (s2y_ff[SW-1:31] == {(SW-31){s2y_ff[SW-1]}}) begin
            saty = s2y_ff[31:0];
         end else begin
            saty = s2y_ff[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end
      end
   end else begin : g_fit
      always_comb begin
         satx = 32'(s2x_ff);
         saty = 32'(s2y_ff);
      end
   end

   always_ff @(posedge clock) begin
      st_f3_ff <= st_f2_ff;
      ox3_ff   <= (st_f2_ff == sgi_pkg::STATUS_HIT) ? satx : '0;
      oy3_ff   <= (st_f2_ff == sgi_pkg::STATUS_HIT) ? saty : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1v_ff <= 1'b0;
         f2v_ff <= 1'b0;
         f3v_ff <= 1'b0;
      end else begin
         f1v_ff <= cv[Q];
         f2v_ff <= f1v_ff;
         f3v_ff <= f2v_ff;
      end
   end

   assign busy        = 1'b0;
   assign rsp_valid   = f3v_ff;
   assign rsp_status  = st_f3_ff;
   assign rsp_cross_x = ox3_ff;
   assign rsp_cross_y = oy3_ff;

   `ASSERT_IMPL(a_zero_miss, clock, reset,
      rsp_valid && rsp_status != sgi_pkg::STATUS_HIT,
      rsp_cross_x == '0 && rsp_cross_y == '0)
   `ASSERT_IMPL(a_status_code, clock, reset, rsp_valid,
      rsp_status == sgi_pkg::STATUS_HIT || rsp_status == sgi_pkg::STATUS_PARALLEL ||
      rsp_status == sgi_pkg::STATUS_OUTSIDE)
   `ASSERT_NEXT(a_chain_entry, clock, reset, v7_ff, cv[1])
   `ASSERT_NEXT(a_chain_exit, clock, reset, cv[Q], f1v_ff)

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_intersection_core. Drives segment pairs
// through the command port, predicts status and the Q16.16 crossing point of
// each word with exact wide arithmetic, and checks every strobed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int FRAC       = 16;
   localparam int LATENCY    = 42;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   } seg_word_type;

   typedef struct packed {
      sgi_pkg::status_type status;
      logic signed [31:0]  cx;
      logic signed [31:0]  cy;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   seg_word_type drv = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_cross_x, rsp_cross_y;

   crossing_type crossing_q[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int hits = 0;
   int idle_pct = 0;
   int stall_cnt = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   segment_intersection_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(drv.ax1), .req_a_start_y(drv.ay1),
      .req_a_end_x(drv.ax2), .req_a_end_y(drv.ay2),
      .req_b_start_x(drv.bx1), .req_b_start_y(drv.by1),
      .req_b_end_x(drv.bx2), .req_b_end_y(drv.by2),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   function automatic logic signed [31:0] sat32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic crossing_type predict_crossing(seg_word_type w);
      longint dax, day, dbx, dby, ox, oy, det, snum, tnum;
      logic signed [127:0] wax, way, wdax, wday, wdet, wsn;
      crossing_type r;
      dax = longint'(w.ax2) - longint'(w.ax1);
      day = longint'(w.ay2) - longint'(w.ay1);
      dbx = longint'(w.bx2) - longint'(w.bx1);
      dby = longint'(w.by2) - longint'(w.by1);
      ox = longint'(w.bx1) - longint'(w.ax1);
      oy = longint'(w.by1) - longint'(w.ay1);
      det = dbx * day - dby * dax;
      snum = dbx * oy - dby * ox;
      tnum = dax * oy - day * ox;
      r = '0;
      if (det == 0) begin
         r.status = sgi_pkg::STATUS_PARALLEL;
         return r;
      end
      if (det < 0) begin
         det = -det;
         snum = -snum;
         tnum = -tnum;
      end
      if (snum < 0 || snum > det || tnum < 0 || tnum > det) begin
         r.status = sgi_pkg::STATUS_OUTSIDE;
         return r;
      end
      wax = 128'(w.ax1);
      way = 128'(w.ay1);
      wdax = 128'(dax);
      wday = 128'(day);
      wdet = 128'(det);
      wsn = 128'(snum);
      r.status = sgi_pkg::STATUS_HIT;
      r.cx = sat32(((wax * wdet + wdax * wsn) <<< FRAC) / wdet);
      r.cy = sat32(((way * wdet + wday * wsn) <<< FRAC) / wdet);
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      crossing_type e;
      if (!reset && rsp_valid) begin
         received++;
         if (crossing_q.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = crossing_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_cross_x !== e.cx) begin
               $error("cross_x expected %0d actual %0d", e.cx, rsp_cross_x);
               errors++;
            end
            if (rsp_cross_y !== e.cy) begin
               $error("cross_y expected %0d actual %0d", e.cy, rsp_cross_y);
               errors++;
            end
            if (e.status == sgi_pkg::STATUS_HIT) hits++;
         end
      end
   end

   // watchdog on cycles without any accepted word or result
   initial begin
      forever begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) stall_cnt = 0;
         else stall_cnt++;
         if (stall_cnt >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cnt);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_word(seg_word_type w);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      drv <= w;
      do @(posedge clock); while (busy);
      crossing_q.push_back(predict_crossing(w));
      sent++;
      @(negedge clock);
   endtask

   task automatic send_seg(int ax1, int ay1, int ax2, int ay2,
                           int bx1, int by1, int bx2, int by2);
      seg_word_type w;
      w.ax1 = 16'(ax1); w.ay1 = 16'(ay1); w.ax2 = 16'(ax2); w.ay2 = 16'(ay2);
      w.bx1 = 16'(bx1); w.by1 = 16'(by1); w.bx2 = 16'(bx2); w.by2 = 16'(by2);
      send_word(w);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (crossing_q.size() != 0) @(negedge clock);
   endtask

   function automatic int rnd_in(int r);
      return $urandom_range(2 * r) - r;
   endfunction

   task automatic test_directed();
      send_seg(0, 0, 10, 10, 0, 10, 10, 0);                    // plain cross
      send_seg(0, 0, 10, 0, 10, 0, 10, 10);                    // shared endpoint
      send_seg(0, 0, 10, 0, 5, 0, 5, 10);                      // T at B start
      send_seg(0, 0, 10, 0, 0, 5, 10, 5);                      // parallel
      send_seg(0, 0, 10, 0, 2, 0, 20, 0);                      // collinear
      send_seg(3, 3, 3, 3, 0, 0, 9, 9);                        // degenerate A
      send_seg(0, 0, 9, 9, -4, 7, -4, 7);                      // degenerate B
      send_seg(0, 0, 10, 0, 20, -5, 20, 5);                    // outside A
      send_seg(0, 0, 10, 0, 5, 1, 5, 9);                       // outside B
      send_seg(0, 10, 10, 0, 0, 0, 10, 10);                    // negative det
      send_seg(0, 0, 3, 0, 1, -1, 2, 2);                       // fractional point
      send_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_seg(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
      send_seg(-32768, 0, 32767, 0, 0, -32768, 1, 32767);
      send_seg(-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767);
      send_seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32766);
      send_seg(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767);
      send_seg(-1, -1, 1, 1, -1, 1, 1, -2);
      send_seg(0, 0, 1, 3, 0, 1, 2, 0);
      send_seg(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
   endtask

   task automatic test_random(int n);
      seg_word_type w;
      int k, r, sel;
      for (k = 0; k < n; k++) begin
         sel = $urandom_range(9);
         r = (sel < 3) ? $urandom_range(64, 2) : (sel < 6) ? $urandom_range(4000, 100)
             : 32767;
         w.ax1 = 16'(rnd_in(r)); w.ay1 = 16'(rnd_in(r));
         w.ax2 = 16'(rnd_in(r)); w.ay2 = 16'(rnd_in(r));
         w.bx1 = 16'(rnd_in(r)); w.by1 = 16'(rnd_in(r));
         w.bx2 = 16'(rnd_in(r)); w.by2 = 16'(rnd_in(r));
         if (sel == 0) begin
            // B parallel to A through a random offset
            w.bx2 = w.bx1 + (w.ax2 - w.ax1);
            w.by2 = w.by1 + (w.ay2 - w.ay1);
         end else if (sel == 9) begin
            w[127:64] = {$urandom, $urandom};
            w[63:0] = {$urandom, $urandom};
         end
         send_word(w);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 32;
      test_directed();
      drain();
      test_random(150);
      idle_pct = 85;
      test_random(150);
      drain();
      idle_pct = 0;
      test_random(150);
      drain();
      repeat (LATENCY + 8) @(negedge clock);
      $display("sent %0d segment pairs, checked %0d results, %0d hits", sent, received,
               hits);
      $display("directed edge cases plus random pairs at three sender idle rates");
      if (errors == 0 && crossing_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
